[design/smt_pkg.sv]
`timescale 1ns / 1ps
// types and codes shared by the sparse transpose block
// no dependencies
package smt_pkg;

  typedef enum logic [1:0] {
    FN_INSERT = 2'd0,
    FN_READ   = 2'd1,
    FN_CLEAR  = 2'd2,
    FN_UNUSED = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    RS_ENTRY    = 3'd0,
    RS_EMPTY    = 3'd1,
    RS_FULL     = 3'd2,
    RS_RANGE    = 3'd3,
    RS_CLEARED  = 3'd4,
    RS_INSERTED = 3'd5
  } status_t;

  typedef enum logic [4:0] {
    ST_SWEEP   = 5'b00001,
    ST_IDLE    = 5'b00010,
    ST_LOOK    = 5'b00100,
    ST_WALK    = 5'b01000,
    ST_CLRDONE = 5'b10000
  } state_t;

  typedef struct packed {
    func_t              func;
    logic [15:0]        src_row;
    logic [9:0]         src_col;
    logic signed [31:0] entry_value;
  } in_item_t;

  typedef struct packed {
    status_t            status;
    logic [9:0]         out_row;
    logic [15:0]        out_col;
    logic signed [31:0] out_value;
    logic [5:0]         row_count;
    logic               last;
  } res_t;

  localparam logic [10:0] COLUMN_LIMIT_RESET = 11'd1024;

endpackage

[design/smt_if.sv]
`timescale 1ns / 1ps
// channel interfaces of the sparse transpose block: input, result, configuration
// no dependencies
interface smt_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         func;
  logic [15:0]        src_row;
  logic [9:0]         src_col;
  logic signed [31:0] entry_value;
  modport source(output valid, func, src_row, src_col, entry_value, input ready);
  modport sink(input valid, func, src_row, src_col, entry_value, output ready);
endinterface

interface smt_out_if;
  logic               valid;
  logic               ready;
  logic [2:0]         status;
  logic [9:0]         out_row;
  logic [15:0]        out_col;
  logic signed [31:0] out_value;
  logic [5:0]         row_count;
  logic               last;
  modport source(output valid, status, out_row, out_col, out_value, row_count, last,
                 input ready);
  modport sink(input valid, status, out_row, out_col, out_value, row_count, last,
               output ready);
endinterface

interface smt_cfg_if;
  logic        valid;
  logic        ready;
  logic [10:0] column_limit;
  modport source(output valid, column_limit, input ready);
  modport sink(input valid, column_limit, output ready);
endinterface

[design/sparse_matrix_transpose.sv]
`timescale 1ns / 1ps
// top level of the sparse transpose block: config register, result register
// depends on smt_pkg, smt_if, smt_seq
//
//  channel   dir  handshake     payload
//  in_ch     in   valid/ready   func, src_row, src_col, entry_value
//  out_ch    out  valid/ready   status, out_row, out_col, out_value, row_count, last
//  cfg_ch    in   valid/ready   column_limit
//
// insert, empty read and rejected items: accepted in IDLE, then the result from LOOK.
// a read of n entries gives n results, one entry per cycle from the entry memory read
// port while the result register is free. a clear sweeps min(MAX_COLUMNS, 1024)
// fill count memory columns, one column per cycle; reset runs it too, input held off.
// a held-off result register stalls the sequencer; the next item is taken only once the
// last result of the current one sits in the result register. config writes always taken.
module sparse_matrix_transpose #(
  parameter int MAX_COLUMNS  = 1024,
  parameter int BUCKET_DEPTH = 32
) (
  input logic       clk,
  input logic       rst_n,
  smt_in_if.sink    in_ch,
  smt_out_if.source out_ch,
  smt_cfg_if.sink   cfg_ch
);
  import smt_pkg::*;

  logic [10:0] column_limit_r;
  logic        out_valid_r;
  res_t        out_r;
  res_t        res;
  logic        res_valid, res_free;
  in_item_t    in_item;

  assign in_item.func        = func_t'(in_ch.func);
  assign in_item.src_row     = in_ch.src_row;
  assign in_item.src_col     = in_ch.src_col;
  assign in_item.entry_value = in_ch.entry_value;

  smt_seq #(.MAX_COLUMNS(MAX_COLUMNS), .BUCKET_DEPTH(BUCKET_DEPTH)) u_seq (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_ch.valid),
    .in_ready     (in_ch.ready),
    .in_item      (in_item),
    .column_limit (column_limit_r),
    .res_valid    (res_valid),
    .res          (res),
    .res_free     (res_free)
  );

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      column_limit_r <= COLUMN_LIMIT_RESET;
    end else if (cfg_ch.valid) begin
      column_limit_r <= cfg_ch.column_limit;
    end
  end

  // single result register between sequencer and sink
  assign res_free = !out_valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
    if (res_valid) begin
      out_r <= res;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.status    = out_r.status;
  assign out_ch.out_row   = out_r.out_row;
  assign out_ch.out_col   = out_r.out_col;
  assign out_ch.out_value = out_r.out_value;
  assign out_ch.row_count = out_r.row_count;
  assign out_ch.last      = out_r.last;

  a_res_fits: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |-> res_free)
    else $error("result produced while result register busy");

  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> !in_ch.ready)
    else $error("item taken while previous item in flight");

  a_sweep_after_reset: assert property (@(posedge clk)
    !rst_n |=> !in_ch.ready)
    else $error("input taken before fill count sweep");

  a_entry_not_last_early: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && !res.last |=> !in_ch.ready)
    else $error("input taken in the middle of a row");

endmodule

[design/smt_ram.sv]
`timescale 1ns / 1ps
// generic single write port ram with registered read
// no dependencies
module smt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[design/smt_seq.sv]
`timescale 1ns / 1ps
// sequencer: fill count memory, entry memory and the per-item state machine
// depends on smt_pkg, smt_ram
module smt_seq #(
  parameter int MAX_COLUMNS  = 1024,
  parameter int BUCKET_DEPTH = 32
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  smt_pkg::in_item_t in_item,
  input  logic [10:0]     column_limit,
  output logic            res_valid,
  output smt_pkg::res_t   res,
  input  logic            res_free
);
  import smt_pkg::*;

  localparam int COL_DEPTH = (MAX_COLUMNS < 1024) ? MAX_COLUMNS : 1024;
  localparam int CAW = $clog2(COL_DEPTH);
  localparam int ENT_DEPTH = COL_DEPTH * BUCKET_DEPTH;
  localparam int EAW = $clog2(ENT_DEPTH);
  localparam int FW = $clog2(BUCKET_DEPTH + 1);
  localparam logic [16:0] MAX_COLS = 17'(MAX_COLUMNS);
  localparam logic [FW-1:0] BD = FW'(BUCKET_DEPTH);
  localparam logic [CAW-1:0] SWEEP_END = CAW'(COL_DEPTH - 1);

  state_t             state_r, state_nxt;
  func_t              func_r, func_nxt;
  logic [15:0]        row_r, row_nxt;
  logic [9:0]         col_r, col_nxt;
  logic signed [31:0] val_r, val_nxt;
  logic               range_r, range_nxt;
  logic [FW-1:0]      fill_r, fill_nxt;
  logic [FW-1:0]      idx_r, idx_nxt;
  logic [CAW-1:0]     sweep_r, sweep_nxt;
  logic               clr_pend_r, clr_pend_nxt;

  logic           fill_we, fill_re;
  logic [CAW-1:0] fill_waddr;
  logic [FW-1:0]  fill_wdata, fill_rd;
  logic           ent_we, ent_re;
  logic [EAW-1:0] ent_waddr, ent_raddr;
  logic [47:0]    ent_rd;
  logic [FW-1:0]  idx_inc, fill_inc;
  logic [EAW-1:0] addr_at_fill, addr_first, addr_next;
  logic           walk_last;

  smt_ram #(.WIDTH(FW), .DEPTH(COL_DEPTH)) u_fill_ram (
    .clk   (clk),
    .we    (fill_we),
    .waddr (fill_waddr),
    .wdata (fill_wdata),
    .re    (fill_re),
    .raddr (in_item.src_col[CAW-1:0]),
    .rdata (fill_rd)
  );

  smt_ram #(.WIDTH(48), .DEPTH(ENT_DEPTH)) u_entry_ram (
    .clk   (clk),
    .we    (ent_we),
    .waddr (ent_waddr),
    .wdata ({row_r, val_r}),
    .re    (ent_re),
    .raddr (ent_raddr),
    .rdata (ent_rd)
  );

  assign idx_inc   = idx_r + FW'(1);
  assign fill_inc  = fill_rd + FW'(1);
  assign walk_last = (idx_inc == fill_r);
  assign addr_at_fill = EAW'(32'(col_r) * BUCKET_DEPTH + 32'(fill_rd));
  assign addr_first   = EAW'(32'(col_r) * BUCKET_DEPTH);
  assign addr_next    = EAW'(32'(col_r) * BUCKET_DEPTH + 32'(idx_inc));
  assign ent_waddr    = addr_at_fill;

  // one item at a time: a count written back in LOOK is settled before the
  // next item's read, so no forwarding path is needed
  always_comb begin
    state_nxt    = state_r;
    func_nxt     = func_r;
    row_nxt      = row_r;
    col_nxt      = col_r;
    val_nxt      = val_r;
    range_nxt    = range_r;
    fill_nxt     = fill_r;
    idx_nxt      = idx_r;
    sweep_nxt    = sweep_r;
    clr_pend_nxt = clr_pend_r;
    in_ready     = 1'b0;
    fill_we      = 1'b0;
    fill_re      = 1'b0;
    fill_waddr   = col_r[CAW-1:0];
    fill_wdata   = fill_inc;
    ent_we       = 1'b0;
    ent_re       = 1'b0;
    ent_raddr    = addr_first;
    res_valid    = 1'b0;
    res          = '0;
    res.status   = RS_RANGE;
    res.out_row  = col_r;
    res.last     = 1'b1;
    case (state_r)
      ST_SWEEP: begin
        fill_we    = 1'b1;
        fill_waddr = sweep_r;
        fill_wdata = '0;
        if (sweep_r == SWEEP_END) begin
          sweep_nxt = '0;
          state_nxt = clr_pend_r ? ST_CLRDONE : ST_IDLE;
        end else begin
          sweep_nxt = sweep_r + CAW'(1);
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          func_nxt  = in_item.func;
          row_nxt   = in_item.src_row;
          col_nxt   = in_item.src_col;
          val_nxt   = in_item.entry_value;
          range_nxt = ({1'b0, in_item.src_col} < column_limit) &&
                      (17'(in_item.src_col) < MAX_COLS);
          fill_re   = 1'b1;
          if (in_item.func == FN_CLEAR) begin
            clr_pend_nxt = 1'b1;
            sweep_nxt    = '0;
            state_nxt    = ST_SWEEP;
          end else begin
            state_nxt = ST_LOOK;
          end
        end
      end
      ST_LOOK: begin
        if (func_r == FN_UNUSED || func_r == FN_CLEAR || !range_r) begin
          res_valid = res_free;
          if (res_free) state_nxt = ST_IDLE;
        end else if (func_r == FN_INSERT) begin
          res_valid = res_free;
          if (fill_rd >= BD) begin
            res.status    = RS_FULL;
            res.row_count = 6'(fill_rd);
          end else begin
            res.status    = RS_INSERTED;
            res.row_count = 6'(fill_inc);
            fill_we       = res_free;
            ent_we        = res_free;
          end
          if (res_free) state_nxt = ST_IDLE;
        end else if (fill_rd == '0) begin
          res.status = RS_EMPTY;
          res_valid  = res_free;
          if (res_free) state_nxt = ST_IDLE;
        end else begin
          ent_re    = 1'b1;
          ent_raddr = addr_first;
          fill_nxt  = fill_rd;
          idx_nxt   = '0;
          state_nxt = ST_WALK;
        end
      end
      ST_WALK: begin
        res.status    = RS_ENTRY;
        res.out_col   = ent_rd[47:32];
        res.out_value = ent_rd[31:0];
        res.row_count = 6'(fill_r);
        res.last      = walk_last;
        res_valid     = res_free;
        if (res_free) begin
          if (walk_last) begin
            state_nxt = ST_IDLE;
          end else begin
            idx_nxt   = idx_inc;
            ent_re    = 1'b1;
            ent_raddr = addr_next;
          end
        end
      end
      ST_CLRDONE: begin
        res.status  = RS_CLEARED;
        res.out_row = '0;
        res_valid   = res_free;
        if (res_free) begin
          clr_pend_nxt = 1'b0;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_SWEEP;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_SWEEP;
      sweep_r    <= '0;
      clr_pend_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      sweep_r    <= sweep_nxt;
      clr_pend_r <= clr_pend_nxt;
    end
    func_r  <= func_nxt;
    row_r   <= row_nxt;
    col_r   <= col_nxt;
    val_r   <= val_nxt;
    range_r <= range_nxt;
    fill_r  <= fill_nxt;
    idx_r   <= idx_nxt;
  end

endmodule
